FILE: rtl/slnt_pkg.sv
// slnt_pkg: shared types and constants for the sorted leaf node table
// entry layout, input and result words, action and status codes, sequencer states
// no dependencies
package slnt_pkg;

    localparam int DATA_W       = 32;
    localparam int ADDR_W       = 6;
    localparam int COUNT_W      = 7;
    localparam int ACTION_W     = 3;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT   = 3'd0,
        ACT_SPLIT    = 3'd1,
        ACT_LOCATE   = 3'd2,
        ACT_READ     = 3'd3,
        ACT_SET_NEXT = 3'd4,
        ACT_CLEAR    = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_NOREC  = 2'd2,
        ST_BADIDX = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RD,
        S_INS,
        S_INS0,
        S_EMIT_RD,
        S_EMIT_LD,
        S_PUT
    } t_state;

    typedef struct packed {
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] page;
        logic signed [DATA_W-1:0] slot;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] raddr;
    } t_ram_ctl;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] rec_page;
        logic signed [DATA_W-1:0] rec_slot;
        logic [ADDR_W-1:0]        entry_index;
        logic signed [DATA_W-1:0] next_page;
    } t_in_word;

    typedef struct packed {
        t_status                  status;
        logic [ADDR_W-1:0]        found_index;
        logic signed [DATA_W-1:0] out_key;
        logic signed [DATA_W-1:0] out_page;
        logic signed [DATA_W-1:0] out_slot;
        logic [COUNT_W-1:0]       count_after;
        logic signed [DATA_W-1:0] next_out;
        logic                     last;
    } t_out_word;

endpackage

FILE: rtl/sorted_leaf_node_table.sv
// sorted_leaf_node_table: one sorted b+ tree leaf with a small sequencer
// depends on slnt_pkg, slnt_entry_ram, slnt_key_cmp
//
// Input channel i_in_valid / o_in_ready carries one t_in_word per action;
// output channel o_out_valid / i_out_ready carries t_out_word results, the
// final result of each action has last set. One action is worked at a time;
// o_in_ready is high only while the sequencer is idle.
// Each action is paced by the single store read port and the shared key
// comparator visiting one entry per cycle:
//   insert: shifts entries up from the end until the slot is found; a full
//           or empty node needs no shift
//   locate: scans up from entry 0 to the first key not below the target
//   read_entry, set_next, clear: no scan of the store
//   split: scans for the slot, emits the upper half of the merged entries
//          (the new one included where it falls), then shifts the kept
//          part in place when the new entry lands in it
// Results sit in one output register; a stalled receiver holds the
// sequencer in its output step and nothing is lost or repeated.
// Reset clears the entry count, the next pointer, the output valid flag and
// the sequencer state; the store itself is not cleared, so the block is ready
// as soon as reset is released.
module sorted_leaf_node_table import slnt_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int                 RAM_AW    = $clog2(CAPACITY);
    localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

    t_state             r_state, n_state;
    t_in_word           r_in, n_in;
    logic [COUNT_W-1:0] r_count, n_count;
    logic signed [DATA_W-1:0] r_next, n_next;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic [COUNT_W-1:0] r_pos, n_pos;
    logic [COUNT_W-1:0] r_j, n_j;
    logic [COUNT_W-1:0] r_total, n_total;
    logic               r_split, n_split;
    t_status            r_status, n_status;
    logic [ADDR_W-1:0]  r_found, n_found;
    t_entry             r_ent, n_ent;
    logic               r_last, n_last;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out_word, n_out_word;

    t_ram_ctl           ram_ctl;
    t_entry             ram_wdata;
    t_entry             ram_rdata;
    t_entry             new_ent;
    logic               key_lt;
    logic               ins_stop;
    logic [COUNT_W-1:0] total_c;
    logic [COUNT_W-1:0] keep_c;

    slnt_entry_ram #(
        .DEPTH (CAPACITY),
        .AW    (RAM_AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (ram_ctl),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    slnt_key_cmp u_cmp (
        .i_a  (ram_rdata.key),
        .i_b  (r_in.key),
        .o_lt (key_lt)
    );

    assign new_ent  = '{key: r_in.key, page: r_in.rec_page, slot: r_in.rec_slot};
    assign total_c  = r_count + COUNT_W'(1);
    assign keep_c   = total_c >> 1;
    assign ins_stop = r_split ? (({1'b0, r_idx} + COUNT_W'(1)) == r_pos) : key_lt;

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_count     = r_count;
        n_next      = r_next;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_j         = r_j;
        n_total     = r_total;
        n_split     = r_split;
        n_status    = r_status;
        n_found     = r_found;
        n_ent       = r_ent;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        ram_ctl     = '0;
        ram_wdata   = new_ent;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in     = i_in_word;
                    n_status = ST_OK;
                    n_found  = '0;
                    n_ent    = '0;
                    n_last   = 1'b1;
                    n_split  = 1'b0;
                    n_state  = S_PUT;
                    unique case (t_action'(i_in_word.action))
                        ACT_INSERT: begin
                            if (r_count >= CAP_COUNT) begin
                                n_status = ST_FULL;
                            end else if (r_count == '0) begin
                                ram_ctl.we    = 1'b1;
                                ram_ctl.waddr = '0;
                                ram_wdata     = '{key: i_in_word.key,
                                                  page: i_in_word.rec_page,
                                                  slot: i_in_word.rec_slot};
                                n_count       = COUNT_W'(1);
                            end else begin
                                ram_ctl.raddr = ADDR_W'(r_count - COUNT_W'(1));
                                n_idx         = ADDR_W'(r_count - COUNT_W'(1));
                                n_state       = S_INS;
                            end
                        end
                        ACT_SPLIT: begin
                            n_split = 1'b1;
                            if (r_count == '0) begin
                                n_pos   = '0;
                                n_count = keep_c;
                                n_total = total_c;
                                n_j     = keep_c;
                                n_state = S_EMIT_RD;
                            end else begin
                                ram_ctl.raddr = '0;
                                n_idx         = '0;
                                n_state       = S_SCAN;
                            end
                        end
                        ACT_LOCATE: begin
                            if (r_count == '0) begin
                                n_status = ST_NOREC;
                            end else begin
                                ram_ctl.raddr = '0;
                                n_idx         = '0;
                                n_state       = S_SCAN;
                            end
                        end
                        ACT_READ: begin
                            if ({1'b0, i_in_word.entry_index} >= r_count) begin
                                n_status = ST_BADIDX;
                            end else begin
                                ram_ctl.raddr = i_in_word.entry_index;
                                n_state       = S_RD;
                            end
                        end
                        ACT_SET_NEXT: begin
                            n_next = i_in_word.next_page;
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!key_lt) begin
                    if (r_split) begin
                        n_pos   = {1'b0, r_idx};
                        n_count = keep_c;
                        n_total = total_c;
                        n_j     = keep_c;
                        n_state = S_EMIT_RD;
                    end else begin
                        n_found = r_idx;
                        n_ent   = ram_rdata;
                        n_state = S_PUT;
                    end
                end else if (({1'b0, r_idx} + COUNT_W'(1)) == r_count) begin
                    if (r_split) begin
                        n_pos   = r_count;
                        n_count = keep_c;
                        n_total = total_c;
                        n_j     = keep_c;
                        n_state = S_EMIT_RD;
                    end else begin
                        n_status = ST_NOREC;
                        n_state  = S_PUT;
                    end
                end else begin
                    ram_ctl.raddr = r_idx + ADDR_W'(1);
                    n_idx         = r_idx + ADDR_W'(1);
                end
            end
            S_RD: begin
                n_ent   = ram_rdata;
                n_state = S_PUT;
            end
            S_INS: begin
                ram_ctl.we    = 1'b1;
                ram_ctl.waddr = r_idx + ADDR_W'(1);
                if (ins_stop) begin
                    ram_wdata = new_ent;
                    if (r_split) begin
                        n_state = S_IDLE;
                    end else begin
                        n_count = r_count + COUNT_W'(1);
                        n_state = S_PUT;
                    end
                end else begin
                    ram_wdata = ram_rdata;
                    if (r_idx == '0) begin
                        n_state = S_INS0;
                    end else begin
                        ram_ctl.raddr = r_idx - ADDR_W'(1);
                        n_idx         = r_idx - ADDR_W'(1);
                    end
                end
            end
            S_INS0: begin
                ram_ctl.we    = 1'b1;
                ram_ctl.waddr = '0;
                ram_wdata     = new_ent;
                if (r_split) begin
                    n_state = S_IDLE;
                end else begin
                    n_count = r_count + COUNT_W'(1);
                    n_state = S_PUT;
                end
            end
            S_EMIT_RD: begin
                n_last = ((r_j + COUNT_W'(1)) == r_total);
                if (r_j == r_pos) begin
                    n_ent   = new_ent;
                    n_state = S_PUT;
                end else begin
                    ram_ctl.raddr = (r_j < r_pos) ? ADDR_W'(r_j)
                                                  : ADDR_W'(r_j - COUNT_W'(1));
                    n_state       = S_EMIT_LD;
                end
            end
            S_EMIT_LD: begin
                n_ent   = ram_rdata;
                n_state = S_PUT;
            end
            S_PUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_word  = '{status:      r_status,
                                    found_index: r_found,
                                    out_key:     r_ent.key,
                                    out_page:    r_ent.page,
                                    out_slot:    r_ent.slot,
                                    count_after: r_count,
                                    next_out:    r_next,
                                    last:        r_last};
                    if (!r_split) begin
                        n_state = S_IDLE;
                    end else if (!r_last) begin
                        n_j     = r_j + COUNT_W'(1);
                        n_state = S_EMIT_RD;
                    end else if (r_pos < r_count) begin
                        // new entry lands in the kept half, shift it in place
                        if (r_pos == (r_count - COUNT_W'(1))) begin
                            ram_ctl.we    = 1'b1;
                            ram_ctl.waddr = ADDR_W'(r_pos);
                            ram_wdata     = new_ent;
                            n_state       = S_IDLE;
                        end else begin
                            ram_ctl.raddr = ADDR_W'(r_count - COUNT_W'(2));
                            n_idx         = ADDR_W'(r_count - COUNT_W'(2));
                            n_state       = S_INS;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_next      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_next      <= n_next;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in       <= n_in;
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_j        <= n_j;
        r_total    <= n_total;
        r_split    <= n_split;
        r_status   <= n_status;
        r_found    <= n_found;
        r_ent      <= n_ent;
        r_last     <= n_last;
        r_out_word <= n_out_word;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_COUNT)
        else $error("entry count above capacity");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_ctl.we |-> ({1'b0, ram_ctl.waddr} < CAP_COUNT))
        else $error("store write beyond capacity");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ({1'b0, r_idx} < r_count))
        else $error("scan index not below entry count");

    a_single_word_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT && !r_split) |-> r_last)
        else $error("single word result without last");

endmodule

FILE: rtl/slnt_entry_ram.sv
// slnt_entry_ram: entry store, one write port and one registered read port
// depends on slnt_pkg (t_entry, t_ram_ctl)
module slnt_entry_ram import slnt_pkg::*; #(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = ADDR_W
) (
    input  logic     i_clk,
    input  t_ram_ctl i_ctl,
    input  t_entry   i_wdata,
    output t_entry   o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr[AW-1:0]] <= i_wdata;
        end
        r_rdata <= r_mem[i_ctl.raddr[AW-1:0]];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/slnt_key_cmp.sv
// slnt_key_cmp: shared signed key comparator used by every scan of the store
// depends on slnt_pkg (DATA_W)
module slnt_key_cmp import slnt_pkg::*; (
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output logic                     o_lt
);

    assign o_lt = (i_a < i_b);

endmodule
